### design/ppw_pkg.sv
// Shared types and constants for the point projection to window block.
`timescale 1ns / 1ps

package ppw_pkg;

    localparam int WORD_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int FIELD_BITS     = 32;
    localparam int INDEX_BITS     = 5;
    localparam int STORE_DEPTH    = 32;
    localparam int VP_POS_BITS    = 16;
    localparam int VP_SIZE_BITS   = 15;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_PROJECT = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_VIEWPORT_X,
        REG_VIEWPORT_Y,
        REG_VIEWPORT_WIDTH,
        REG_VIEWPORT_HEIGHT
    } cfg_reg_t;

    typedef struct packed {
        logic                          kind;
        logic [INDEX_BITS-1:0]         entry_index;
        logic signed [FIELD_BITS-1:0]  entry_value;
        logic signed [FIELD_BITS-1:0]  obj_x;
        logic signed [FIELD_BITS-1:0]  obj_y;
        logic signed [FIELD_BITS-1:0]  obj_z;
    } item_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0]  win_x;
        logic signed [FIELD_BITS-1:0]  win_y;
        logic signed [FIELD_BITS-1:0]  win_z;
        logic                          projected;
    } result_t;

    typedef struct packed {
        logic signed [VP_POS_BITS-1:0] x;
        logic signed [VP_POS_BITS-1:0] y;
        logic [VP_SIZE_BITS-1:0]       width;
        logic [VP_SIZE_BITS-1:0]       height;
    } viewport_t;

endpackage

### design/point_projection_to_window_core.sv
// Top level of the point projection to window block: matrix store, pipeline and output register.
`timescale 1ns / 1ps

// Projects object-space points to window coordinates in the manner of gluProject.
// A load item (kind 0) writes one Q16.16 element of the model matrix (entries 0-15) or
// the projection matrix (entries 16-31), both column-major, and gives no result. A project
// item (kind 1) is transformed by the model matrix, then the projection matrix; if clip w
// is below 0.0001 the result carries projected = 0 and zero coordinates, otherwise it
// gets the perspective divide and the viewport map. Rate: one item per cycle, sustained
// while the output register is not stalled and no projection load is held back. A point
// passes the transform (two four-stage matrix units), the divider (one quotient bit per
// stage), the viewport map and the output register. A load to a projection entry is held
// back while a point is still inside the model-matrix unit, since that point has yet to
// read the projection matrix. The matrix store has no reset; every entry a point uses must
// be loaded first. The user must write viewport registers through cfg_we / cfg_index /
// cfg_data only while the block is idle; the block itself does not enforce this.

module point_projection_to_window_core
    import ppw_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  item_t                     item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output result_t                   result,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [WORD_BITS-1:0] ONE =
        (FRAC_BITS <= WORD_BITS - 2) ? (WORD_BITS'(1) << FRAC_BITS) : WMAX;
    localparam int XW = (WORD_BITS > FIELD_BITS) ? WORD_BITS : FIELD_BITS;

    // input field into the internal word, clamped when the word is narrower
    function automatic logic signed [WORD_BITS-1:0] to_word(
        input logic signed [FIELD_BITS-1:0] v
    );
        logic signed [XW-1:0] e;
        e = XW'(v);
        if (e > XW'(WMAX))
            return WMAX;
        else if (e < XW'(WMIN))
            return WMIN;
        else
            return e[WORD_BITS-1:0];
    endfunction

    // ---------------- configuration ----------------
    viewport_t vp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vp_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_VIEWPORT_X:      vp_reg.x      <= $signed(cfg_data[VP_POS_BITS-1:0]);
                REG_VIEWPORT_Y:      vp_reg.y      <= $signed(cfg_data[VP_POS_BITS-1:0]);
                REG_VIEWPORT_WIDTH:  vp_reg.width  <= cfg_data[VP_SIZE_BITS-1:0];
                REG_VIEWPORT_HEIGHT: vp_reg.height <= cfg_data[VP_SIZE_BITS-1:0];
            endcase
        end
    end

    // ---------------- handshake ----------------
    // The whole pipe moves together; it only halts when its last stage holds an item
    // and the output register is full and not being taken. Bubbles keep moving.
    logic en;
    logic win_valid;
    logic xf1_busy;
    logic item_acc;
    logic is_load;
    logic is_proj_load;
    logic proj_in;

    assign en           = !(win_valid && result_valid && !result_ready);
    assign is_load      = (item.kind == KIND_LOAD);
    assign is_proj_load = is_load && item.entry_index[INDEX_BITS-1];
    assign item_ready   = en && !(is_proj_load && xf1_busy);
    assign item_acc     = item_valid && item_ready;
    assign proj_in      = item_acc && (item.kind == KIND_PROJECT);

    // ---------------- matrix store ----------------
    logic signed [WORD_BITS-1:0] store_reg [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (item_acc && is_load)
            store_reg[item.entry_index] <= to_word(item.entry_value);
    end

    logic signed [WORD_BITS-1:0] model_mat [16];
    logic signed [WORD_BITS-1:0] proj_mat  [16];
    logic signed [WORD_BITS-1:0] pt        [4];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            model_mat[i] = store_reg[i];
            proj_mat[i]  = store_reg[i+16];
        end
        pt[0] = to_word(item.obj_x);
        pt[1] = to_word(item.obj_y);
        pt[2] = to_word(item.obj_z);
        pt[3] = ONE;
    end

    // ---------------- transforms ----------------
    logic                        eye_valid;
    logic signed [WORD_BITS-1:0] eye [4];
    logic                        clip_valid;
    logic signed [WORD_BITS-1:0] clip [4];
    logic                        xf2_busy;

    ppw_xform #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_xform_model (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (proj_in),
        .mat       (model_mat),
        .vec       (pt),
        .busy      (xf1_busy),
        .out_valid (eye_valid),
        .out_vec   (eye)
    );

    // reads the projection half of the store as the point leaves the model unit
    ppw_xform #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_xform_proj (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (eye_valid),
        .mat       (proj_mat),
        .vec       (eye),
        .busy      (xf2_busy),
        .out_valid (clip_valid),
        .out_vec   (clip)
    );

    // ---------------- perspective divide ----------------
    logic signed [WORD_BITS-1:0] div_num [3];
    logic signed [WORD_BITS-1:0] ndc [3];
    logic                        ndc_valid;
    logic                        ndc_proj;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
            div_num[l] = clip[l];
    end

    ppw_div #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (clip_valid),
        .num       (div_num),
        .den       (clip[3]),
        .out_valid (ndc_valid),
        .out_proj  (ndc_proj),
        .quot      (ndc)
    );

    // ---------------- viewport map ----------------
    result_t win_result;

    ppw_window #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (ndc_valid),
        .in_proj    (ndc_proj),
        .ndc        (ndc),
        .vp         (vp_reg),
        .out_valid  (win_valid),
        .out_result (win_result)
    );

    // ---------------- output register ----------------
    logic    result_valid_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (!result_valid_reg || result_ready)
            result_valid_reg <= win_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!result_valid_reg || result_ready)
            result_reg <= win_result;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------- assertions ----------------
    // a projection load never overtakes a point that still has to read the projection matrix
    a_no_store_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        (item_acc && is_proj_load) |-> !xf1_busy)
        else $error("projection matrix written while a point is in the model unit");

    // an unprojected result carries zero coordinates
    a_unprojected_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.projected) |->
        (result.win_x == '0 && result.win_y == '0 && result.win_z == '0))
        else $error("unprojected result with nonzero coordinates");

    // a halted pipe keeps its finished item at the end
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> win_valid)
        else $error("item lost from last stage during stall");

    // the second transform is busy one unit behind the first
    a_xf2_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (eye_valid && en) |=> xf2_busy)
        else $error("point left the model unit but did not enter the projection unit");

endmodule

### design/ppw_xform.sv
// Four-stage 4x4 matrix by vector transform with rounded, saturated products and sums.
`timescale 1ns / 1ps

module ppw_xform
    import ppw_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [WORD_BITS-1:0] mat [16],
    input  logic signed [WORD_BITS-1:0] vec [4],
    output logic                        busy,
    output logic                        out_valid,
    output logic signed [WORD_BITS-1:0] out_vec [4]
);

    localparam int PW = 2 * WORD_BITS;
    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (FRAC_BITS - 1);

    // round to nearest, ties away from zero, then saturate to the word
    function automatic logic signed [WORD_BITS-1:0] sat_prod(input logic signed [PW-1:0] p);
        logic signed [PW:0] t;
        t = $signed({p[PW-1], p}) + HALF - $signed({{PW{1'b0}}, p[PW-1]});
        t = t >>> FRAC_BITS;
        if (t > (PW+1)'(WMAX))
            return WMAX;
        else if (t < (PW+1)'(WMIN))
            return WMIN;
        else
            return t[WORD_BITS-1:0];
    endfunction

    function automatic logic signed [WORD_BITS-1:0] sat_add(
        input logic signed [WORD_BITS-1:0] a,
        input logic signed [WORD_BITS-1:0] b
    );
        logic signed [WORD_BITS:0] s;
        s = $signed({a[WORD_BITS-1], a}) + $signed({b[WORD_BITS-1], b});
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WMIN : WMAX;
        else
            return s[WORD_BITS-1:0];
    endfunction

    logic [3:0]                  v_reg;
    logic signed [PW-1:0]        prod_reg [4][4];
    logic signed [WORD_BITS-1:0] rnd_reg  [4][4];
    logic signed [WORD_BITS-1:0] acc_reg  [4];
    logic signed [WORD_BITS-1:0] last_reg [4];
    logic signed [WORD_BITS-1:0] sum_reg  [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    prod_reg[r][c] <= PW'(mat[c*4+r]) * PW'(vec[c]);
                    rnd_reg[r][c]  <= sat_prod(prod_reg[r][c]);
                end
                // column order kept: ((p0 + p1) + p2) + p3
                acc_reg[r]  <= sat_add(sat_add(rnd_reg[r][0], rnd_reg[r][1]), rnd_reg[r][2]);
                last_reg[r] <= rnd_reg[r][3];
                sum_reg[r]  <= sat_add(acc_reg[r], last_reg[r]);
            end
        end
    end

    assign busy      = |v_reg;
    assign out_valid = v_reg[3];
    assign out_vec   = sum_reg;

endmodule

### design/ppw_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes over a shared divisor.
`timescale 1ns / 1ps

module ppw_div
    import ppw_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [WORD_BITS-1:0] num [3],
    input  logic signed [WORD_BITS-1:0] den,
    output logic                        out_valid,
    output logic                        out_proj,
    output logic signed [WORD_BITS-1:0] quot [3]
);

    localparam int N = WORD_BITS + FRAC_BITS;
    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam longint unsigned THRESH_RAW = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic signed [WORD_BITS-1:0] THRESH =
        (THRESH_RAW == 64'd0) ? WORD_BITS'(1) : WORD_BITS'(THRESH_RAW);
    localparam logic [N:0] LIM_POS = (N+1)'(WMAX);
    localparam logic [N:0] LIM_NEG = LIM_POS + (N+1)'(1);

    logic [WORD_BITS-2:0] rem_reg [N][3];
    logic [N-1:0]         nq_reg  [N][3];
    logic                 neg_reg [N][3];
    logic [WORD_BITS-2:0] d_reg   [N];
    logic [N-1:0]         proj_reg;
    logic [N-1:0]         v_reg;

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [WORD_BITS-2:0] rem_i [3];
        logic [N-1:0]         nq_i  [3];
        logic                 neg_i [3];
        logic [WORD_BITS-2:0] d_i;
        logic                 p_i;
        logic                 v_i;
        logic [WORD_BITS-1:0] trial [3];
        logic [WORD_BITS-1:0] diff  [3];
        logic                 ge    [3];

        if (s == 0)
        begin : g_first
            always_comb
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_i[l] = '0;
                    neg_i[l] = num[l][WORD_BITS-1];
                    nq_i[l]  = {(num[l][WORD_BITS-1] ? WORD_BITS'(-num[l]) : num[l]),
                                {FRAC_BITS{1'b0}}};
                end
                d_i = den[WORD_BITS-2:0];
                p_i = (den >= THRESH);
                v_i = in_valid;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_i[l] = rem_reg[s-1][l];
                    neg_i[l] = neg_reg[s-1][l];
                    nq_i[l]  = nq_reg[s-1][l];
                end
                d_i = d_reg[s-1];
                p_i = proj_reg[s-1];
                v_i = v_reg[s-1];
            end
        end

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                trial[l] = {rem_i[l], nq_i[l][N-1]};
                diff[l]  = trial[l] - {1'b0, d_i};
                ge[l]    = (trial[l] >= {1'b0, d_i});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en)
                v_reg[s] <= v_i;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[s][l] <= ge[l] ? diff[l][WORD_BITS-2:0]
                                           : trial[l][WORD_BITS-2:0];
                    nq_reg[s][l]  <= {nq_i[l][N-2:0], ge[l]};
                    neg_reg[s][l] <= neg_i[l];
                end
                d_reg[s]    <= d_i;
                proj_reg[s] <= p_i;
            end
        end
    end

    // final rounding (half or more of the divisor rounds up) and saturation
    logic                        v_out_reg;
    logic                        proj_out_reg;
    logic signed [WORD_BITS-1:0] quot_reg [3];
    logic [N:0]                  q1 [3];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            q1[l] = {1'b0, nq_reg[N-1][l]}
                  + (N+1)'(rem_reg[N-1][l] >= (d_reg[N-1] - rem_reg[N-1][l]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_out_reg <= 1'b0;
        else if (en)
            v_out_reg <= v_reg[N-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (neg_reg[N-1][l])
                    quot_reg[l] <= (q1[l] > LIM_NEG) ? WMIN : WORD_BITS'(-q1[l]);
                else
                    quot_reg[l] <= (q1[l] > LIM_POS) ? WMAX : WORD_BITS'(q1[l]);
            end
            proj_out_reg <= proj_reg[N-1];
        end
    end

    assign out_valid = v_out_reg;
    assign out_proj  = proj_out_reg;
    assign quot      = quot_reg;

endmodule

### design/ppw_window.sv
// Three-stage viewport mapping: offset by one, scale x and y by size, halve, add origin to x and y.
`timescale 1ns / 1ps

module ppw_window
    import ppw_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic                        in_proj,
    input  logic signed [WORD_BITS-1:0] ndc [3],
    input  viewport_t                   vp,
    output logic                        out_valid,
    output result_t                     out_result
);

    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [WORD_BITS-1:0] ONE =
        (FRAC_BITS <= WORD_BITS - 2) ? (WORD_BITS'(1) << FRAC_BITS) : WMAX;
    localparam int OW = VP_POS_BITS + FRAC_BITS;
    localparam int CW = (OW > WORD_BITS) ? OW : WORD_BITS;
    localparam int MW = WORD_BITS + VP_SIZE_BITS + 1;

    function automatic logic signed [WORD_BITS-1:0] sat_add(
        input logic signed [WORD_BITS-1:0] a,
        input logic signed [WORD_BITS-1:0] b
    );
        logic signed [WORD_BITS:0] s;
        s = $signed({a[WORD_BITS-1], a}) + $signed({b[WORD_BITS-1], b});
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WMIN : WMAX;
        else
            return s[WORD_BITS-1:0];
    endfunction

    // pixel origin moved into the word
    function automatic logic signed [WORD_BITS-1:0] origin(
        input logic signed [VP_POS_BITS-1:0] o
    );
        logic signed [CW-1:0] t;
        t = CW'(o) <<< FRAC_BITS;
        if (t > CW'(WMAX))
            return WMAX;
        else if (t < CW'(WMIN))
            return WMIN;
        else
            return t[WORD_BITS-1:0];
    endfunction

    function automatic logic signed [WORD_BITS-1:0] sat_scale(
        input logic signed [WORD_BITS-1:0] a,
        input logic [VP_SIZE_BITS-1:0]     sz
    );
        logic signed [MW-1:0] p;
        p = MW'(a) * MW'($signed({1'b0, sz}));
        if (p > MW'(WMAX))
            return WMAX;
        else if (p < MW'(WMIN))
            return WMIN;
        else
            return p[WORD_BITS-1:0];
    endfunction

    // divide by two, ties away from zero
    function automatic logic signed [WORD_BITS-1:0] halve(input logic signed [WORD_BITS-1:0] a);
        logic signed [WORD_BITS:0] e;
        e = $signed({a[WORD_BITS-1], a}) + $signed({{WORD_BITS{1'b0}}, ~a[WORD_BITS-1]});
        e = e >>> 1;
        return e[WORD_BITS-1:0];
    endfunction

    logic [2:0]                  v_reg;
    logic [1:0]                  proj_reg;
    logic signed [WORD_BITS-1:0] t1_reg [3];
    logic signed [WORD_BITS-1:0] o1_reg [2];
    logic signed [WORD_BITS-1:0] t2_reg [3];
    logic signed [WORD_BITS-1:0] o2_reg [2];
    result_t                     res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
                t1_reg[l] <= sat_add(ONE, ndc[l]);
            o1_reg[0]   <= origin(vp.x);
            o1_reg[1]   <= origin(vp.y);
            proj_reg[0] <= in_proj;

            t2_reg[0]   <= sat_scale(t1_reg[0], vp.width);
            t2_reg[1]   <= sat_scale(t1_reg[1], vp.height);
            t2_reg[2]   <= t1_reg[2];
            o2_reg      <= o1_reg;
            proj_reg[1] <= proj_reg[0];

            if (proj_reg[1])
            begin
                res_reg.win_x     <= FIELD_BITS'(sat_add(o2_reg[0], halve(t2_reg[0])));
                res_reg.win_y     <= FIELD_BITS'(sat_add(o2_reg[1], halve(t2_reg[1])));
                res_reg.win_z     <= FIELD_BITS'(halve(t2_reg[2]));
                res_reg.projected <= 1'b1;
            end
            else
            begin
                res_reg <= '0;
            end
        end
    end

    assign out_valid  = v_reg[2];
    assign out_result = res_reg;

endmodule
